// ===== sv/gvc_pkg.sv =====
package gvc_pkg;

    // Vertex and colour fields are six bits wide, so at most 64 vertices exist
    localparam int VTX_W            = 6;
    localparam int VTX_LIMIT        = 1 << VTX_W;
    localparam int COLOR_W          = 6;
    localparam int NUM_COLORS       = 1 << COLOR_W;
    localparam int VERTICES_DEFAULT = 64;

    // Lowest-free search looks at one byte of the used-colour mask per cycle
    localparam int CHUNK_W    = 8;
    localparam int CHUNK_SEL  = $clog2(CHUNK_W);
    localparam int NUM_CHUNKS = NUM_COLORS / CHUNK_W;
    localparam int STEP_W     = COLOR_W - CHUNK_SEL;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_EDGE    = 2'd1;
    localparam logic [1:0] MODE_COLOR   = 2'd2;
    localparam logic [1:0] MODE_RESTART = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR_A,
        ST_ADD_WR_B,
        ST_COL_RD,
        ST_COL_NBR,
        ST_COL_SCAN,
        ST_COL_LAST,
        ST_COL_SEARCH,
        ST_COL_DONE
    } gvc_state_t;

    typedef struct packed {
        logic clear;
        logic wr_en;
    } adj_cmd_t;

    typedef struct packed {
        logic               done;
        logic [COLOR_W-1:0] color;
    } search_res_t;

endpackage

// ===== sv/gvc_adj_mem.sv =====
module gvc_adj_mem
    import gvc_pkg::*;
#(
    parameter int LIVE = VERTICES_DEFAULT,
    parameter int AW   = $clog2(LIVE)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  adj_cmd_t        cmd,
    input  logic [AW-1:0]   wr_addr,
    input  logic [LIVE-1:0] wr_data,
    input  logic [AW-1:0]   rd_addr,
    output logic [LIVE-1:0] rd_data
);

    logic [LIVE-1:0] rows [LIVE];
    logic [LIVE-1:0] row_valid_reg;
    logic [LIVE-1:0] rd_data_reg;
    logic            rd_valid_reg;

    // Row storage carries no reset; a row that is not valid reads as no edges
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            rows[wr_addr] <= wr_data;
        end
        rd_data_reg <= rows[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= row_valid_reg[rd_addr];
            if (cmd.clear)
            begin
                row_valid_reg <= '0;
            end
            else if (cmd.wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== sv/gvc_color_mem.sv =====
module gvc_color_mem
    import gvc_pkg::*;
#(
    parameter int LIVE = VERTICES_DEFAULT,
    parameter int AW   = $clog2(LIVE)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [COLOR_W-1:0] wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [COLOR_W-1:0] rd_data
);

    logic [COLOR_W-1:0] colors [LIVE];
    logic [COLOR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            colors[wr_addr] <= wr_data;
        end
        rd_data_reg <= colors[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/gvc_free_search.sv =====
module gvc_free_search
    import gvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [NUM_COLORS-1:0] used,
    output search_res_t           res
);

    logic [NUM_COLORS-1:0] used_reg, used_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COLOR_W-1:0]    pick_reg, pick_next;

    logic [CHUNK_W-1:0]    free_bits;
    logic [CHUNK_SEL-1:0]  pos;

    always_comb
    begin
        free_bits = ~used_reg[step_reg*CHUNK_W +: CHUNK_W];
        pos       = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                pos = CHUNK_SEL'(i);
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        pick_next = pick_reg;
        if (start)
        begin
            used_next = used;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (|free_bits)
            begin
                pick_next = {step_reg, pos};
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (step_reg == STEP_W'(NUM_CHUNKS - 1))
            begin
                // Every colour taken: hold the top colour
                pick_next = COLOR_W'(NUM_COLORS - 1);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        used_reg <= used_next;
        step_reg <= step_next;
        pick_reg <= pick_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign res.done  = done_reg;
    assign res.color = pick_reg;

endmodule

// ===== sv/greedy_vertex_coloring.sv =====
// Greedy vertex colouring over an undirected graph of L = min(VERTICES, 64)
// vertices held as an adjacency bit matrix. Each input item is one of four
// commands: clear the graph (also ends the colouring pass), add an edge
// (self edges and absent vertices are dropped), restart the pass keeping the
// edges, or colour the next vertex of the order. Only a colour command on an
// existing vertex yields a result item: the vertex, the lowest colour unused
// by its neighbours already coloured in this pass, and a flag set when the
// vertex was already coloured in this pass. The block takes one item at a
// time and holds in_stall high while it works. Clear, restart and ignored
// commands end as they are taken; an edge runs ST_ADD_RD, ST_ADD_WR_A and
// ST_ADD_WR_B, a read-modify-write of each endpoint row through the single
// adjacency read port. A colour command does one row read, then one read of
// the colour memory per vertex through its single read port, then a lowest-free
// search over the used-colour mask one byte a cycle. A finished result waits
// in the output register, so the next item is taken while it is still pending.
module greedy_vertex_coloring
    import gvc_pkg::*;
#(
    parameter int VERTICES = VERTICES_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic [VTX_W-1:0]   vertex_a,
    input  logic [VTX_W-1:0]   vertex_b,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [VTX_W-1:0]   colored_vertex,
    output logic [COLOR_W-1:0] assigned_color,
    output logic               repeat_flag
);

    localparam int LIVE = (VERTICES < VTX_LIMIT) ? VERTICES : VTX_LIMIT;
    localparam int VW   = $clog2(LIVE);
    localparam logic [LIVE-1:0] ONE_LIVE = {{(LIVE - 1){1'b0}}, 1'b1};
    localparam logic [NUM_COLORS-1:0] ONE_COLOR = {{(NUM_COLORS - 1){1'b0}}, 1'b1};

    gvc_state_t state_reg, state_next;

    logic [VW-1:0]         a_reg, a_next;
    logic [VW-1:0]         b_reg, b_next;
    logic [LIVE-1:0]       marks_reg, marks_next;
    logic [LIVE-1:0]       nbrs_reg, nbrs_next;
    logic [NUM_COLORS-1:0] used_reg, used_next;
    logic [VW-1:0]         cnt_reg, cnt_next;
    logic                  hit_reg, hit_next;
    logic                  repeat_reg, repeat_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VTX_W-1:0]      out_vertex_reg, out_vertex_next;
    logic [COLOR_W-1:0]    out_color_reg, out_color_next;
    logic                  out_repeat_reg, out_repeat_next;

    adj_cmd_t              adj_cmd;
    logic [VW-1:0]         adj_wr_addr;
    logic [LIVE-1:0]       adj_wr_data;
    logic [VW-1:0]         adj_rd_addr;
    logic [LIVE-1:0]       adj_rd_data;

    logic                  col_wr_en;
    logic [COLOR_W-1:0]    col_rd_data;

    logic                  search_start;
    search_res_t           search_res;

    logic                  in_take;
    logic                  a_exists;
    logic                  b_exists;
    logic                  out_free;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign a_exists = ({1'b0, vertex_a} < (VTX_W + 1)'(LIVE));
    assign b_exists = ({1'b0, vertex_b} < (VTX_W + 1)'(LIVE));
    assign out_free = !out_valid_reg || !out_stall;

    // Second endpoint is read while the first row is written back
    assign adj_rd_addr = (state_reg == ST_ADD_WR_A) ? b_reg : a_reg;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        marks_next      = marks_reg;
        nbrs_next       = nbrs_reg;
        used_next       = used_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        repeat_next     = repeat_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_vertex_next = out_vertex_reg;
        out_color_next  = out_color_reg;
        out_repeat_next = out_repeat_reg;
        adj_cmd.clear   = 1'b0;
        adj_cmd.wr_en   = 1'b0;
        adj_wr_addr     = a_reg;
        adj_wr_data     = adj_rd_data | (ONE_LIVE << b_reg);
        col_wr_en       = 1'b0;
        search_start    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    a_next = vertex_a[VW-1:0];
                    b_next = vertex_b[VW-1:0];
                    case (mode)
                        MODE_CLEAR:
                        begin
                            adj_cmd.clear = 1'b1;
                            marks_next    = '0;
                        end
                        MODE_EDGE:
                        begin
                            if (a_exists && b_exists && (vertex_a != vertex_b))
                            begin
                                state_next = ST_ADD_RD;
                            end
                        end
                        MODE_COLOR:
                        begin
                            if (a_exists)
                            begin
                                state_next = ST_COL_RD;
                            end
                        end
                        MODE_RESTART:
                        begin
                            marks_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD_RD:
            begin
                state_next = ST_ADD_WR_A;
            end
            ST_ADD_WR_A:
            begin
                adj_cmd.wr_en = 1'b1;
                state_next    = ST_ADD_WR_B;
            end
            ST_ADD_WR_B:
            begin
                adj_cmd.wr_en = 1'b1;
                adj_wr_addr   = b_reg;
                adj_wr_data   = adj_rd_data | (ONE_LIVE << a_reg);
                state_next    = ST_IDLE;
            end
            ST_COL_RD:
            begin
                state_next = ST_COL_NBR;
            end
            ST_COL_NBR:
            begin
                // Keep only neighbours coloured in this pass
                nbrs_next   = adj_rd_data & marks_reg;
                repeat_next = marks_reg[a_reg];
                used_next   = '0;
                cnt_next    = '0;
                hit_next    = 1'b0;
                state_next  = ST_COL_SCAN;
            end
            ST_COL_SCAN:
            begin
                // Colour of the vertex issued last cycle arrives now
                if (hit_reg)
                begin
                    used_next = used_reg | (ONE_COLOR << col_rd_data);
                end
                hit_next = nbrs_reg[cnt_reg];
                if (cnt_reg == VW'(LIVE - 1))
                begin
                    state_next = ST_COL_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COL_LAST:
            begin
                if (hit_reg)
                begin
                    used_next = used_reg | (ONE_COLOR << col_rd_data);
                end
                hit_next     = 1'b0;
                search_start = 1'b1;
                state_next   = ST_COL_SEARCH;
            end
            ST_COL_SEARCH:
            begin
                if (search_res.done)
                begin
                    state_next = ST_COL_DONE;
                end
            end
            ST_COL_DONE:
            begin
                // Hold until the output register is free, then commit
                if (out_free)
                begin
                    col_wr_en       = 1'b1;
                    marks_next      = marks_reg | (ONE_LIVE << a_reg);
                    out_valid_next  = 1'b1;
                    out_vertex_next = VTX_W'(a_reg);
                    out_color_next  = search_res.color;
                    out_repeat_next = repeat_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            marks_reg     <= marks_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        nbrs_reg       <= nbrs_next;
        used_reg       <= used_next;
        cnt_reg        <= cnt_next;
        repeat_reg     <= repeat_next;
        out_vertex_reg <= out_vertex_next;
        out_color_reg  <= out_color_next;
        out_repeat_reg <= out_repeat_next;
    end

    gvc_adj_mem #(
        .LIVE (LIVE),
        .AW   (VW)
    ) u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (adj_cmd),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data)
    );

    gvc_color_mem #(
        .LIVE (LIVE),
        .AW   (VW)
    ) u_color_mem (
        .clk     (clk),
        .wr_en   (col_wr_en),
        .wr_addr (a_reg),
        .wr_data (search_res.color),
        .rd_addr (cnt_reg),
        .rd_data (col_rd_data)
    );

    gvc_free_search u_free_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (search_start),
        .used  (used_next),
        .res   (search_res)
    );

    assign out_valid      = out_valid_reg;
    assign colored_vertex = out_vertex_reg;
    assign assigned_color = out_color_reg;
    assign repeat_flag    = out_repeat_reg;

endmodule
